@@ rtl/vrt_pkg.sv @@
// Shared constants, types and helpers for the voxel ray traversal block.
package vrt_pkg;

	localparam int GRID_SIDE = 32;
	localparam int FRAC_BITS = 8;
	localparam int CELL_W    = 5;
	localparam int COORD_W   = 16;
	localparam int ROWS      = GRID_SIDE * GRID_SIDE;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int X_W       = $clog2(GRID_SIDE);
	localparam int D_W       = COORD_W + 1;
	localparam int MAG_W     = D_W;
	localparam int NUM_W     = D_W + 1;
	localparam int PROD_W    = NUM_W + MAG_W;
	localparam int POS_W     = 10;
	localparam int VOX_W     = 9;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_T_RD,
		ST_T_CHK,
		ST_SEL_A,
		ST_SEL_B,
		ST_SEL_C,
		ST_STEP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ROW_AW-1:0] addr;
		logic [GRID_SIDE-1:0] wdata;
	} mem_req_t;

	function automatic logic [ROW_AW-1:0] row_addr(input int y, input int z);
		row_addr = ROW_AW'(y + GRID_SIDE * z);
	endfunction

endpackage

@@ rtl/vrt_occ_mem.sv @@
// Occupancy store: one row of voxels along x per word, registered read.
module vrt_occ_mem import vrt_pkg::*; (
	input  logic                 clk,
	input  mem_req_t             req,
	output logic [GRID_SIDE-1:0] rdata
);

	logic [GRID_SIDE-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

@@ rtl/vrt_mul.sv @@
// Shared multiplier for the axis compare, product registered.
module vrt_mul import vrt_pkg::*; (
	input  logic              clk,
	input  logic [NUM_W-1:0]  a,
	input  logic [MAG_W-1:0]  b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

@@ rtl/voxel_ray_traversal_top.sv @@
// Top level of the voxel ray traversal block: sequencer, axis state and glue.
//
// Slave channel (s_*) takes requests: tuser bit 0 selects a voxel write or a
// ray trace. A write sets or clears one voxel and returns nothing. A trace
// walks the voxels along start..end (Q8.8) and returns one result on the
// master channel (m_*): hit flag in tuser, last voxel reached in tdata.
//
// One request at a time: s_tready is high only while idle. A write goes
// through accept, row read, and modify and write back. A trace has a set-up
// step (the accepting cycle), then per visited voxel a row read and a check,
// then for each axis after the first ST_SEL_A, ST_SEL_B and ST_SEL_C on the
// shared multiplier (cross-multiplied compare of boundary distances) if it
// moves or ST_SEL_A alone if it is still, a closing ST_SEL_A and ST_STEP.
// A hit ends the walk right after the check. The result is held in an
// output register until m_tready takes it; a stalled receiver simply
// holds the block in that state.
//
// After reset the block clears the occupancy store row by row, all ROWS
// (GRID_SIDE squared, 1024) rows, while s_tready stays low.
module voxel_ray_traversal_top import vrt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_x[4:0], cell_y[9:5], cell_z[14:10], solid[15], start_x[31:16],
	// start_y[47:32], start_z[63:48], end_x[79:64], end_y[95:80], end_z[111:96]
	input  logic [111:0] s_tdata,
	// op[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// voxel_x[8:0], voxel_y[17:9], voxel_z[26:18], zero pad above
	output logic [31:0]  m_tdata,
	// hit[0]
	output logic [0:0]   m_tuser
);

	state_t state_q, state_d;

	logic [ROW_AW-1:0]    clr_q;
	logic [ROW_AW-1:0]    wr_row_q;
	logic [X_W-1:0]       wr_bit_q;
	logic                 wr_val_q;
	logic                 wr_ok_q;
	logic [GRID_SIDE-1:0] rdata;
	mem_req_t             mreq;

	// per-axis walk state
	logic signed [POS_W-1:0] pos_q [3];
	logic [NUM_W-1:0]        num_q [3];
	logic [MAG_W-1:0]        mag_q [3];
	logic                    neg_q [3];
	logic [1:0]              m_q, cand_q;
	logic [PROD_W-1:0]       p1_q, prod_q;
	logic                    hit_q, inside_q;
	logic [NUM_W-1:0]        mul_a;
	logic [MAG_W-1:0]        mul_b;
	logic [1:0]              first_nz;
	logic                    any_nz;
	logic                    cur_inside;

	logic [CELL_W-1:0] cx, cy, cz;
	assign cx = s_tdata[4:0];
	assign cy = s_tdata[9:5];
	assign cz = s_tdata[14:10];

	always_comb begin
		any_nz   = 1'b1;
		first_nz = 2'd0;
		priority if (mag_q[0] != '0) first_nz = 2'd0;
		else if (mag_q[1] != '0) first_nz = 2'd1;
		else if (mag_q[2] != '0) first_nz = 2'd2;
		else any_nz = 1'b0;
	end

	always_comb begin
		cur_inside = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (pos_q[a] < 0 || pos_q[a] >= POS_W'(GRID_SIDE)) cur_inside = 1'b0;
		end
	end

	// memory port
	always_comb begin
		mreq.we    = 1'b0;
		mreq.wdata = rdata;
		mreq.addr  = wr_row_q;
		unique case (state_q)
			ST_CLEAR: begin
				mreq.we    = 1'b1;
				mreq.addr  = clr_q;
				mreq.wdata = '0;
			end
			ST_WR_WB: begin
				mreq.we = wr_ok_q;
				mreq.wdata[wr_bit_q] = wr_val_q;
			end
			ST_T_RD: mreq.addr = row_addr(int'(pos_q[1][X_W-1:0]), int'(pos_q[2][X_W-1:0]));
			default: ;
		endcase
	end

	vrt_occ_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_SEL_A) begin
			mul_a = num_q[cand_q];
			mul_b = mag_q[m_q];
		end else begin
			mul_a = num_q[m_q];
			mul_b = mag_q[cand_q];
		end
	end

	vrt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == ROW_AW'(ROWS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_tvalid) state_d = (s_tuser[0] == OP_TRACE) ? ST_T_RD : ST_WR_RD;
			end
			ST_WR_RD: state_d = ST_WR_WB;
			ST_WR_WB: state_d = ST_IDLE;
			ST_T_RD:  state_d = any_nz ? ST_T_CHK : ST_OUT;
			ST_T_CHK: state_d = (inside_q && rdata[pos_q[0][X_W-1:0]]) ? ST_OUT : ST_SEL_A;
			ST_SEL_A: begin
				if (cand_q == 2'd3) state_d = ST_STEP;
				else if (mag_q[cand_q] != '0) state_d = ST_SEL_B;
			end
			ST_SEL_B: state_d = ST_SEL_C;
			ST_SEL_C: state_d = ST_SEL_A;
			ST_STEP:  state_d = (NUM_W'(num_q[m_q]) < NUM_W'(mag_q[m_q])) ? ST_T_RD : ST_OUT;
			ST_OUT:   if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE) hit_q <= 1'b0;
			if (state_q == ST_T_CHK && inside_q && rdata[pos_q[0][X_W-1:0]]) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				wr_row_q <= row_addr(int'(cy), int'(cz));
				wr_bit_q <= X_W'(cx);
				wr_val_q <= s_tdata[15];
				wr_ok_q  <= (int'(cx) < GRID_SIDE) && (int'(cy) < GRID_SIDE) &&
				            (int'(cz) < GRID_SIDE);
				for (int a = 0; a < 3; a++) begin
					logic signed [COORD_W-1:0] s, e;
					logic signed [D_W-1:0]     d;
					logic [FRAC_BITS-1:0]      fr;
					s  = s_tdata[16 + COORD_W*a +: COORD_W];
					e  = s_tdata[64 + COORD_W*a +: COORD_W];
					d  = D_W'(e) - D_W'(s);
					fr = s[FRAC_BITS-1:0];
					pos_q[a] <= POS_W'(s >>> FRAC_BITS);
					neg_q[a] <= d < 0;
					mag_q[a] <= (d < 0) ? MAG_W'(-d) : MAG_W'(d);
					if (d > 0) num_q[a] <= NUM_W'(1 << FRAC_BITS) - NUM_W'(fr);
					else if (d < 0) num_q[a] <= NUM_W'(fr);
					else num_q[a] <= '0;
				end
			end
			ST_T_RD: inside_q <= cur_inside;
			ST_T_CHK: begin
				m_q    <= first_nz;
				cand_q <= first_nz + 2'd1;
			end
			ST_SEL_A: if (cand_q != 2'd3 && mag_q[cand_q] == '0) cand_q <= cand_q + 2'd1;
			ST_SEL_B: p1_q <= prod_q;
			ST_SEL_C: begin
				// strictly nearer boundary wins; ties keep the earlier axis
				if (p1_q < prod_q) m_q <= cand_q;
				cand_q <= cand_q + 2'd1;
			end
			ST_STEP: begin
				pos_q[m_q] <= neg_q[m_q] ? pos_q[m_q] - 1'b1 : pos_q[m_q] + 1'b1;
				num_q[m_q] <= num_q[m_q] + NUM_W'(1 << FRAC_BITS);
			end
			default: ;
		endcase
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = (state_q == ST_OUT);
	assign m_tuser[0] = hit_q;
	assign m_tdata    = {5'b0, pos_q[2][VOX_W-1:0], pos_q[1][VOX_W-1:0], pos_q[0][VOX_W-1:0]};

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("accepting while a result is pending");
	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> pos_q[0] >= 0 && pos_q[1] >= 0 && pos_q[2] >= 0 &&
		pos_q[0] < POS_W'(GRID_SIDE) && pos_q[1] < POS_W'(GRID_SIDE) &&
		pos_q[2] < POS_W'(GRID_SIDE)) else $error("hit reported outside the grid");
	a_out_from_trace: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_T_RD || $past(state_q) == ST_T_CHK ||
		$past(state_q) == ST_STEP) else $error("result without a trace");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the voxel ray traversal block: random writes and traces, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
	import vrt_pkg::*;

	// One expected trace outcome: hit flag and last voxel reached
	typedef struct {
		logic             hit;
		logic [VOX_W-1:0] vx;
		logic [VOX_W-1:0] vy;
		logic [VOX_W-1:0] vz;
	} trace_outcome_t;

	// Keeps its own copy of the occupancy grid, walks each trace with exact
	// integer DDA and queues the outcome for the output side to compare.
	class trace_scoreboard;
		bit             occ [GRID_SIDE*GRID_SIDE*GRID_SIDE];
		trace_outcome_t pending_traces [$];
		int             errors;

		function new();
			foreach (occ[i]) occ[i] = 0;
			errors = 0;
		endfunction

		function bit solid_at(int p [3]);
			for (int a = 0; a < 3; a++)
				if (p[a] < 0 || p[a] >= GRID_SIDE) return 0;
			return occ[p[0] + GRID_SIDE * (p[1] + GRID_SIDE * p[2])];
		endfunction

		// Note one accepted request; a trace queues its predicted outcome
		function void note_request(logic op, logic [111:0] d);
			int             pos [3];
			int             stp [3];
			longint         num [3];
			longint         mag [3];
			longint         ent_num;
			longint         ent_den;
			bit             any;
			bit             hit;
			int             m;
			int             s;
			int             e;
			int             df;
			int             fr;
			trace_outcome_t o;
			if (op == OP_WRITE) begin
				occ[d[4:0] + GRID_SIDE * (d[9:5] + GRID_SIDE * d[14:10])] = d[15];
				return;
			end
			any = 0;
			hit = 0;
			ent_num = 0;
			ent_den = 1;
			for (int a = 0; a < 3; a++) begin
				s  = int'($signed(d[16 + 16*a +: 16]));
				e  = int'($signed(d[64 + 16*a +: 16]));
				df = e - s;
				fr = s & ((1 << FRAC_BITS) - 1);
				pos[a] = s >>> FRAC_BITS;
				if (df > 0) begin
					stp[a] = 1;  mag[a] = longint'(df);
					num[a] = longint'((1 << FRAC_BITS) - fr);
				end else if (df < 0) begin
					stp[a] = -1; mag[a] = longint'(-df); num[a] = longint'(fr);
				end else begin
					stp[a] = 0;  mag[a] = 0;   num[a] = 0;
				end
				if (df != 0) any = 1;
			end
			if (any) begin
				while (ent_num < ent_den) begin
					if (solid_at(pos)) begin
						hit = 1;
						break;
					end
					m = -1;
					for (int a = 0; a < 3; a++) begin
						if (mag[a] == 0) continue;
						// ties go to the lower axis
						if (m < 0 || num[a] * mag[m] < num[m] * mag[a]) m = a;
					end
					ent_num = num[m];
					ent_den = mag[m];
					pos[m] += stp[m];
					num[m] += longint'(1 << FRAC_BITS);
				end
			end
			o.hit = hit;
			o.vx  = pos[0][VOX_W-1:0];
			o.vy  = pos[1][VOX_W-1:0];
			o.vz  = pos[2][VOX_W-1:0];
			pending_traces.push_back(o);
		endfunction

		function void check_result(logic hit, logic [31:0] d);
			trace_outcome_t o;
			if (pending_traces.size() == 0) begin
				$error("unexpected result hit=%0d data=%h", hit, d);
				errors++;
				return;
			end
			o = pending_traces.pop_front();
			if (hit !== o.hit) begin
				$error("hit: expected %0d actual %0d", o.hit, hit); errors++;
			end
			if (d[8:0] !== o.vx) begin
				$error("voxel_x: expected %0d actual %0d", $signed(o.vx), $signed(d[8:0]));
				errors++;
			end
			if (d[17:9] !== o.vy) begin
				$error("voxel_y: expected %0d actual %0d", $signed(o.vy), $signed(d[17:9]));
				errors++;
			end
			if (d[26:18] !== o.vz) begin
				$error("voxel_z: expected %0d actual %0d", $signed(o.vz), $signed(d[26:18]));
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;

	trace_scoreboard sb;
	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  rx_hold;
	int  requests_sent;

	voxel_ray_traversal_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Receiver: random back-pressure, or a long hold-off while rx_hold is set
	always @(negedge clk) begin
		m_tready = !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// Outputs sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
	end

	// Offer one request from the falling edge on until it is taken; random
	// gaps are inserted before it as the current idle rate asks.
	task automatic send_request(logic op, logic [111:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid   = 1'b1;
		s_tuser[0] = op;
		s_tdata    = d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, d);
		requests_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_voxel(int x, int y, int z, bit solid);
		logic [111:0] d;
		d = 112'({$urandom, $urandom, $urandom, $urandom});
		d[4:0] = 5'(x); d[9:5] = 5'(y); d[14:10] = 5'(z); d[15] = solid;
		send_request(OP_WRITE, d);
	endtask

	task automatic trace_ray(int sx, int sy, int sz, int ex, int ey, int ez);
		logic [111:0] d;
		d = 112'({$urandom, $urandom, $urandom, $urandom});
		d[31:16] = 16'(sx); d[47:32] = 16'(sy); d[63:48] = 16'(sz);
		d[79:64] = 16'(ex); d[95:80] = 16'(ey); d[111:96] = 16'(ez);
		send_request(OP_TRACE, d);
	endtask

	// Point near the populated block of the grid, in Q8.8; now and then on a
	// whole cell boundary
	function automatic int near_point();
		int p;
		p = $urandom_range(40 * 256) - 4 * 256;
		if ($urandom_range(5) == 0) p &= ~255;
		return p;
	endfunction

	task automatic random_request();
		int sx, sy, sz, ex, ey, ez;
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			// most writes fall in a dense block so that traces meet solids
			if ($urandom_range(3) == 0)
				write_voxel($urandom_range(31), $urandom_range(31), $urandom_range(31),
					$urandom_range(1));
			else
				write_voxel($urandom_range(15, 6), $urandom_range(15, 6),
					$urandom_range(15, 6), $urandom_range(9) < 7);
		end else if (r < 40) begin
			// full-range end points: long walks, every bit of the fields
			trace_ray($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
		end else begin
			sx = near_point(); sy = near_point(); sz = near_point();
			ex = near_point(); ey = near_point(); ez = near_point();
			if ($urandom_range(4) == 0) ey = sy;
			if ($urandom_range(4) == 0) ez = sz;
			if ($urandom_range(9) == 0) ex = sx;
			trace_ray(sx, sy, sz, ex, ey, ez);
		end
	endtask

	// Long receiver hold-off once the random part is under way
	initial begin
		rx_hold = 1'b0;
		wait (requests_sent >= 120);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (600) @(posedge clk);
		@(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb            = new();
		requests_sent = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		m_tready      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		write_voxel(0, 0, 0, 1);
		write_voxel(31, 31, 31, 1);
		write_voxel(10, 10, 10, 1);
		write_voxel(31, 0, 0, 1);
		trace_ray(-512, 128, 128, 2560, 128, 128);          // hits corner voxel
		trace_ray(8000, 8000, 8000, -1000, -1000, -1000);   // hits far corner
		trace_ray(1234, 1234, 1234, 1234, 1234, 1234);      // zero length
		trace_ray(512, 512, 512, 2816, 512, 512);           // integer start, +x
		trace_ray(2816, 768, 768, 512, 768, 768);           // integer start, -x
		trace_ray(640, 640, 640, 3200, 3200, 3200);         // x/y/z ties, hits 10,10,10
		trace_ray(128, 128, 1000, 5000, 128, 1000);         // z axis zero
		trace_ray(-32768, -32768, -32768, 32767, 32767, 32767);
		trace_ray(32767, -32768, 0, -32768, 32767, 0);
		trace_ray(-9000, 20000, -300, -8000, 21000, -200);  // wholly outside
		trace_ray(7936, 100, 100, 8400, 100, 100);          // starts in solid voxel 31,0,0, hits it
		write_voxel(10, 10, 10, 0);
		trace_ray(640, 640, 640, 3200, 3200, 3200);         // cleared, runs through
		write_voxel(0, 0, 0, 0);
		trace_ray(100, 100, 100, 200, 200, 200);
		trace_ray(-1, -1, -1, -257, -1, -1);                // tiny negatives

		for (int i = 0; i < 450; i++) begin
			if (i == 150) begin
				tx_idle_pct = 54; rx_idle_pct = 33;
			end else if (i == 300) begin
				tx_idle_pct = 0;  rx_idle_pct = 0;
			end else if (i == 0) begin
				tx_idle_pct = 33; rx_idle_pct = 54;
			end
			random_request();
		end

		while (sb.pending_traces.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
